[design/jfs_pkg.sv]
// jfs_pkg: shared types and constants of the jpeg frame size scanner
// marker byte codes, stop cause codes and the result record
// no dependencies
package jfs_pkg;

  // marker bytes
  localparam logic [7:0] MrkPrefix = 8'hFF;
  localparam logic [7:0] MrkSoi    = 8'hD8;
  localparam logic [7:0] MrkEoi    = 8'hD9;
  localparam logic [7:0] MrkTem    = 8'h01;
  localparam logic [7:0] MrkRstLo  = 8'hD0;
  localparam logic [7:0] MrkRstHi  = 8'hD7;
  localparam logic [7:0] MrkSof0   = 8'hC0;
  localparam logic [7:0] MrkSof2   = 8'hC2;

  // why the scan ended
  typedef enum logic [2:0] {
    CauseFound = 3'd0,
    CauseStart = 3'd1,
    CauseEoi   = 3'd2,
    CauseLen   = 3'd3,
    CauseData  = 3'd4
  } cause_e;

  // one result beat
  typedef struct packed {
    logic        found;
    logic [15:0] width;
    logic [15:0] height;
    cause_e      cause;
  } res_t;

endpackage : jfs_pkg

[design/jpeg_frame_size_scanner.sv]
// jpeg_frame_size_scanner: walks the marker segments of a jpeg byte stream
// and reports the frame dimensions from the first sof0/sof2 header
// depends on jfs_pkg
//
// result path: the result goes into the output register, or into the skid entry while out_stall_i holds the output
// throughput: one byte per cycle while the skid entry is empty; the walk state updates in a single pass
// a two-entry output (result register plus skid) lets bytes flow while a result waits
// reset (rst_ni low, asynchronous): scan expects the start marker, size register is 0
module jpeg_frame_size_scanner #(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i,
  // byte input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              start_of_image_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              found_o,
  output logic [15:0]       width_o,
  output logic [15:0]       height_o,
  output jfs_pkg::cause_e   stop_cause_o
);
  import jfs_pkg::*;

  localparam int PB   = POSITION_BITS;
  // wide enough for position + length + 2 against the 16-bit size
  localparam int CmpW = ((PB > 16) ? PB : 16) + 2;

  // scan phases
  localparam logic [2:0] PhSoi0  = 3'd0;
  localparam logic [2:0] PhSoi1  = 3'd1;
  localparam logic [2:0] PhHead  = 3'd2;
  localparam logic [2:0] PhMark  = 3'd3;
  localparam logic [2:0] PhLenHi = 3'd4;
  localparam logic [2:0] PhLenLo = 3'd5;
  localparam logic [2:0] PhSkip  = 3'd6;
  localparam logic [2:0] PhFrame = 3'd7;

  logic [15:0]   size_q;
  logic [PB-1:0] pos_q, pos_d;
  logic [2:0]    phase_q, phase_d;
  logic [PB-1:0] mpos_q, mpos_d;
  logic [7:0]    code_q, code_d;
  logic [15:0]   seg_q, seg_d;
  logic [15:0]   skip_q, skip_d;
  logic [15:0]   hgt_q, hgt_d;
  logic          fin_q, fin_d;

  logic          accept;
  logic          emit;
  res_t          res;
  logic [PB-1:0] pos_eff;
  logic [2:0]    phase_eff;
  logic          fin_eff;
  logic [15:0]   len_full;
  logic [15:0]   skip_dec;
  logic [PB-1:0] off;
  logic [CmpW-1:0] size_ext;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] seg_end;

  logic          out_valid_q, out_valid_d;
  res_t          out_q, out_d;
  logic          skid_valid_q, skid_valid_d;
  res_t          skid_q, skid_d;
  logic          take;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

  // input handshake: only a full skid holds off new bytes
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  // start flag restarts the scan on this byte
  assign pos_eff   = start_of_image_i ? '0 : pos_q;
  assign phase_eff = start_of_image_i ? PhSoi0 : phase_q;
  assign fin_eff   = start_of_image_i ? 1'b0 : fin_q;

  // shared arithmetic for the checks
  assign len_full = {seg_q[15:8], data_byte_i};
  assign skip_dec = skip_q - 16'd1;
  assign off      = pos_eff - mpos_q;
  assign size_ext = CmpW'(size_q);
  assign pos_ext  = CmpW'(pos_eff);
  assign seg_end  = CmpW'(mpos_q) + CmpW'(2) + CmpW'(len_full);

  // segment walk
  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    mpos_d  = mpos_q;
    code_d  = code_q;
    seg_d   = seg_q;
    skip_d  = skip_q;
    hgt_d   = hgt_q;
    fin_d   = fin_q;
    emit    = 1'b0;
    res     = '{found: 1'b0, width: 16'd0, height: 16'd0, cause: CauseStart};

    if (accept) begin
      if (start_of_image_i) begin
        pos_d   = '0;
        phase_d = PhSoi0;
        fin_d   = 1'b0;
      end
      if (!fin_eff) begin
        pos_d = pos_eff + PB'(1);
        unique case (phase_eff)
          PhSoi0: begin
            if (size_q < 16'd4 || data_byte_i != MrkPrefix) begin
              emit      = 1'b1;
              res.cause = CauseStart;
            end else begin
              phase_d = PhSoi1;
            end
          end
          PhSoi1: begin
            if (data_byte_i != MrkSoi) begin
              emit      = 1'b1;
              res.cause = CauseStart;
            end else begin
              phase_d = PhHead;
            end
          end
          PhHead: begin
            if (pos_ext + CmpW'(8) >= size_ext) begin
              emit      = 1'b1;
              res.cause = CauseData;
            end else if (data_byte_i == MrkPrefix) begin
              mpos_d  = pos_eff;
              phase_d = PhMark;
            end
          end
          PhMark: begin
            if (data_byte_i == MrkEoi) begin
              emit      = 1'b1;
              res.cause = CauseEoi;
            end else if (data_byte_i == MrkTem ||
                         (data_byte_i >= MrkRstLo && data_byte_i <= MrkRstHi)) begin
              phase_d = PhHead;
            end else begin
              code_d  = data_byte_i;
              phase_d = PhLenHi;
            end
          end
          PhLenHi: begin
            seg_d   = {data_byte_i, 8'd0};
            phase_d = PhLenLo;
          end
          PhLenLo: begin
            seg_d = len_full;
            if (len_full < 16'd2 || seg_end > size_ext) begin
              emit      = 1'b1;
              res.cause = CauseLen;
            end else if ((code_q == MrkSof0 || code_q == MrkSof2) && len_full >= 16'd7) begin
              phase_d = PhFrame;
            end else begin
              skip_d  = len_full - 16'd2;
              phase_d = (len_full == 16'd2) ? PhHead : PhSkip;
            end
          end
          PhSkip: begin
            skip_d = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_d = PhHead;
            end
          end
          PhFrame: begin
            // height at offsets 5 and 6, width at 7 and 8 from the marker
            priority if (off == PB'(5)) begin
              hgt_d = {data_byte_i, 8'd0};
            end else if (off == PB'(6)) begin
              hgt_d = hgt_q | {8'd0, data_byte_i};
            end else if (off == PB'(7)) begin
              seg_d = {data_byte_i, 8'd0};
            end else if (off >= PB'(8)) begin
              emit       = 1'b1;
              res.found  = 1'b1;
              res.width  = seg_q | {8'd0, data_byte_i};
              res.height = hgt_q;
              res.cause  = CauseFound;
            end
          end
        endcase
        if (emit) begin
          fin_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PhSoi0;
      mpos_q  <= '0;
      code_q  <= '0;
      seg_q   <= '0;
      skip_q  <= '0;
      hgt_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      mpos_q  <= mpos_d;
      code_q  <= code_d;
      seg_q   <= seg_d;
      skip_q  <= skip_d;
      hgt_q   <= hgt_d;
      fin_q   <= fin_d;
    end
  end

  // result register with skid entry
  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (take || !out_valid_q) begin
      out_valid_d  = skid_valid_q || emit;
      out_d        = skid_valid_q ? skid_q : res;
      skid_valid_d = 1'b0;
    end else if (emit) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_q.found;
  assign width_o      = out_q.width;
  assign height_o     = out_q.height;
  assign stop_cause_o = out_q.cause;

  // checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  a_emit_marks_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> fin_q)
    else $error("result given but stream not marked finished");

  a_found_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && found_o) |-> (stop_cause_o == CauseFound))
    else $error("found result with a failure cause");

  a_miss_zero_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_o) |-> (width_o == 16'd0 && height_o == 16'd0 &&
                                   stop_cause_o != CauseFound))
    else $error("missed frame with non-zero dimensions");

  a_no_emit_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fin_q && !start_of_image_i) |-> !emit)
    else $error("second result for one stream");

endmodule : jpeg_frame_size_scanner
